>>> sv/lpp_pkg.sv
// lpp_pkg: widths, framing constants and the result lane type for the lidar packet parser
// no dependencies; compiled first
package lpp_pkg;

  localparam int PACKET_BYTES = 22;
  localparam int KEPT_BYTES   = PACKET_BYTES - 1;
  localparam int ANGLE_COUNT  = 360;
  localparam int LANES        = 4;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 5;
  localparam int ANGLE_W = 9;
  localparam int DIST_W  = 14;

  localparam logic [BYTE_W-1:0] START_BYTE    = 8'hFA;
  localparam logic [BYTE_W-1:0] INDEX_BASE    = 8'hA0;
  localparam logic [BYTE_W-1:0] INDEX_WRAP_AT = 8'hF9;
  localparam logic [BYTE_W-1:0] INDEX_WRAP_TO = 8'h9F;
  localparam logic [BYTE_W-1:0] INVALID_MASK  = 8'h80;
  localparam logic [BYTE_W-1:0] DIST_HI_MASK  = 8'h3F;
  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 14'd6000;

  // byte offsets inside a packet
  localparam logic [POS_W-1:0] POS_INDEX   = 5'd1;
  localparam logic [POS_W-1:0] POS_DATA0   = 5'd4;
  localparam logic [POS_W-1:0] POS_CLOSING = POS_W'(KEPT_BYTES);

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  distance;
  } lane_t;

endpackage

>>> sv/lpp_if.sv
// lpp_if: valid/ready channel interfaces for received bytes and readings
// depends on lpp_pkg
interface lpp_in_if import lpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpp_out_if import lpp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_index;
  logic [DIST_W-1:0]  distance;
  logic               revolution_done;
  logic               last;

  modport source (output valid, output angle_index, output distance,
                  output revolution_done, output last, input ready);
  modport sink   (input valid, input angle_index, input distance,
                  input revolution_done, input last, output ready);
endinterface

>>> sv/lidar_packet_parser.sv
// lidar_packet_parser: frames 22-byte lidar packets and emits up to four readings per packet
// depends on lpp_pkg and the channel interfaces in lpp_if.sv
// readings are registered at the transfer of the closing byte and appear in the cycle after
// throughput: one byte per cycle; a packet's readings drain one per cycle while out_ch.ready
// the closing byte waits only while readings of the previous packet are still queued
// reset (rst_n low, synchronous): framing idle, previous index 0, queue empty,
// max_distance back to 6000
module lidar_packet_parser import lpp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  lpp_in_if.sink              in_ch,
  lpp_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [DIST_W-1:0]   cfg_wdata
);

  // configuration
  logic [DIST_W-1:0] max_distance_r;

  // framing state
  logic              in_packet_r;
  logic [POS_W-1:0]  pos_r;
  logic [BYTE_W-1:0] prev_index_r;

  // packet bytes that the readings need: index byte and the distance pairs
  logic [BYTE_W-1:0] index_r;
  logic [BYTE_W-1:0] lo_r [LANES];
  logic [BYTE_W-1:0] hi_r [LANES];

  // result queue: one lane per reading, a valid mask, shared revolution flag
  lane_t             lane_r [LANES];
  logic [LANES-1:0]  mask_r;
  logic              rev_r;

  logic              in_fire, out_fire, closing, hit, buf_free;
  logic [LANES-1:0]  sel, mask_after, lane_valid;
  lane_t             lane_nxt [LANES];
  logic [BYTE_W-1:0] idx_off;
  logic [ANGLE_W-1:0] base;
  logic              rev_nxt;
  lane_t             out_lane;

  // a transfer of the 22nd byte closes the packet
  assign closing  = in_packet_r && (pos_r >= POS_CLOSING);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // lowest queued lane goes out first
  assign sel        = mask_r & (~mask_r + LANES'(1));
  assign mask_after = out_fire ? (mask_r & ~sel) : mask_r;
  assign buf_free   = (mask_after == '0);

  // only the closing byte needs room in the queue
  assign in_ch.ready = !closing || buf_free;

  // index check against the previous packet, 9-bit sum so no wrap
  assign hit = ({1'b0, index_r} == ({1'b0, prev_index_r} + 9'd1));

  // angle base (index - 0xa0) * 4; meaningful only when index >= 0xa0
  assign idx_off = index_r - INDEX_BASE;
  assign base    = {idx_off[ANGLE_W-3:0], 2'b00};
  assign rev_nxt = (index_r >= INDEX_BASE) &&
                   (({1'b0, base} + 10'd3) >= 10'(ANGLE_COUNT - 1));

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic [DIST_W-1:0] raw;
      raw = {hi_r[k][DIST_W-BYTE_W-1:0] & DIST_HI_MASK[DIST_W-BYTE_W-1:0], lo_r[k]};
      lane_nxt[k].angle = base + ANGLE_W'(k);
      // invalid flag or over the limit reads as zero
      if ((hi_r[k] & INVALID_MASK) != '0) begin
        lane_nxt[k].distance = '0;
      end else if (raw > max_distance_r) begin
        lane_nxt[k].distance = '0;
      end else begin
        lane_nxt[k].distance = raw;
      end
      lane_valid[k] = (index_r >= INDEX_BASE) &&
                      (lane_nxt[k].angle < ANGLE_W'(ANGLE_COUNT));
    end
  end

  // one-hot and-or select of the lane on the output
  always_comb begin
    out_lane = '0;
    for (int k = 0; k < LANES; k++) begin
      if (sel[k]) begin
        out_lane = out_lane | lane_r[k];
      end
    end
  end

  assign out_ch.valid           = |mask_r;
  assign out_ch.angle_index     = out_lane.angle;
  assign out_ch.distance        = out_lane.distance;
  assign out_ch.revolution_done = rev_r;
  assign out_ch.last            = ((mask_r & ~sel) == '0);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_distance_r <= MAX_DIST_RESET;
    end else if (cfg_we) begin
      max_distance_r <= cfg_wdata;
    end
  end

  // framing control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r  <= 1'b0;
      pos_r        <= '0;
      prev_index_r <= '0;
    end else if (in_fire) begin
      if (closing) begin
        // closing byte is swallowed and never opens a packet
        in_packet_r  <= 1'b0;
        pos_r        <= '0;
        prev_index_r <= (index_r >= INDEX_WRAP_AT) ? INDEX_WRAP_TO : index_r;
      end else if (in_packet_r) begin
        pos_r <= pos_r + POS_W'(1);
      end else if (in_ch.rx_byte == START_BYTE) begin
        in_packet_r <= 1'b1;
        pos_r       <= POS_W'(1);
      end
    end
  end

  // packet byte capture, each register at its own offset
  always_ff @(posedge clk) begin
    if (in_fire && in_packet_r && !closing) begin
      if (pos_r == POS_INDEX) begin
        index_r <= in_ch.rx_byte;
      end
      for (int k = 0; k < LANES; k++) begin
        if (pos_r == POS_DATA0 + POS_W'(4 * k)) begin
          lo_r[k] <= in_ch.rx_byte;
        end
        if (pos_r == POS_DATA0 + POS_W'(4 * k + 1)) begin
          hi_r[k] <= in_ch.rx_byte;
        end
      end
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (in_fire && closing && hit) begin
      mask_r <= lane_valid;
    end else begin
      mask_r <= mask_after;
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_fire && closing && hit) begin
      rev_r <= rev_nxt;
      for (int k = 0; k < LANES; k++) begin
        lane_r[k] <= lane_nxt[k];
      end
    end
  end

  // a matching packet with a valid index fills all four lanes
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && closing && hit && (index_r >= INDEX_BASE) && (index_r < INDEX_WRAP_AT + 8'd1))
    |=> (mask_r == 4'b1111))
    else $error("lidar packet parser: queue not filled on matching packet");

  // the last reading empties the queue unless a new packet closes at once
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_ch.last && !(in_fire && closing)) |=> (mask_r == '0))
    else $error("lidar packet parser: queue not empty after last reading");

  // closing byte transfer never overwrites queued readings
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && closing) |-> (mask_after == '0))
    else $error("lidar packet parser: closing byte taken with readings queued");

  // byte position stays in the packet and is zero outside it
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= POS_CLOSING) && (in_packet_r || (pos_r == '0)))
    else $error("lidar packet parser: byte position out of range");

endmodule
